[hdl/conv3x3_plane_accumulate_core_macros.svh]
// assertion macros used by the checker file of the convolution core
`ifndef CONV3X3_PLANE_ACCUMULATE_CORE_MACROS_SVH
`define CONV3X3_PLANE_ACCUMULATE_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define C3PA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c3pa check failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define C3PA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c3pa check failed");

`endif

[hdl/c3pa_pkg.sv]
// shared constants, register codes and result type of the 3x3 convolution core
package c3pa_pkg;

    localparam int MAX_SIZE_DEF    = 256;
    localparam int PIXEL_WIDTH_DEF = 16;

    localparam int CNT_W      = 9;    // row and column counters, output indexes
    localparam int WEIGHT_W   = 16;   // signed q4.12
    localparam int ACC_W      = 48;   // signed q28.20
    localparam int KROW_W     = 48;   // three packed weights
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int SIZE_RESET = 224;

    // output tdata layout
    localparam int OUT_ROW_LSB = 0;
    localparam int OUT_COL_LSB = OUT_ROW_LSB + CNT_W;
    localparam int OUT_ACC_LSB = OUT_COL_LSB + CNT_W;
    localparam int OUT_USED_W  = OUT_ACC_LSB + ACC_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_ROW_0 = 3'd0,
        REG_KERNEL_ROW_1 = 3'd1,
        REG_KERNEL_ROW_2 = 3'd2,
        REG_ACTIVE_SIZE  = 3'd3,
        REG_FIRST_PLANE  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CNT_W-1:0]        row;
        logic [CNT_W-1:0]        col;
        logic signed [ACC_W-1:0] acc;
        logic                    last;
    } result_t;

endpackage

[hdl/conv3x3_plane_accumulate_core.sv]
// 3x3 convolution over a zero-padded plane with a saturating accumulator plane
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: pixel (signed q8.8)
//  m_*     | out | m_tvalid/m_tready  | m_tdata: out_row, out_col, acc_value
//          |     |                    | m_tlast: plane_done
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data (no read-back)
//
// one pixel request per cycle while s_tready is high; after its pixel is taken, a
// window result passes line ram read, window, products, partial sums, accumulate
// the accumulator plane is a ram that is read four stages before it is written
// the pipeline advances as one; an output skid register lets the source go on
// for one result while the sink stalls, then s_tready drops until it drains
// async active-low reset clears control state only; ram contents need no clear,
// the line store is always rewritten in a plane before any window uses it
module conv3x3_plane_accumulate_core #(
    parameter int MAX_SIZE    = c3pa_pkg::MAX_SIZE_DEF,
    parameter int PIXEL_WIDTH = c3pa_pkg::PIXEL_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // pixel request stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((PIXEL_WIDTH + 7) / 8) * 8-1:0] s_tdata,   // [PIXEL_WIDTH-1:0] pixel
    // window result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [c3pa_pkg::OUT_TDATA_W-1:0]       m_tdata,   // [8:0] out_row,
                                                              // [17:9] out_col,
                                                              // [65:18] acc_value
    output logic                                   m_tlast,   // plane_done
    // configuration writes
    input  logic                                   cfg_we,
    input  logic [c3pa_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [c3pa_pkg::CFG_DATA_W-1:0]        cfg_data
);

    import c3pa_pkg::*;

    localparam int LINE_LEN  = MAX_SIZE + 2;
    localparam int LINE_AW   = $clog2(LINE_LEN);
    localparam int ACC_DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int ACC_AW    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
    localparam int PROD_W    = PIXEL_WIDTH + WEIGHT_W;
    localparam int PART_W    = PROD_W + 2;
    localparam int SUM_W     = PROD_W + 4;
    localparam int EXT_W     = ((SUM_W > ACC_W) ? SUM_W : ACC_W) + 1;

    // ---------------- configuration registers ----------------
    logic [KROW_W-1:0] kernel_reg [3];
    logic [CNT_W-1:0]  active_size_reg;
    logic              first_plane_reg;
    logic [CNT_W-1:0]  eff_size;
    logic [CNT_W-1:0]  last_idx;        // padded size minus one

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg[0]   <= '0;
            kernel_reg[1]   <= '0;
            kernel_reg[2]   <= '0;
            active_size_reg <= CNT_W'(SIZE_RESET);
            first_plane_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KERNEL_ROW_0: kernel_reg[0]   <= cfg_data[KROW_W-1:0];
                REG_KERNEL_ROW_1: kernel_reg[1]   <= cfg_data[KROW_W-1:0];
                REG_KERNEL_ROW_2: kernel_reg[2]   <= cfg_data[KROW_W-1:0];
                REG_ACTIVE_SIZE:  active_size_reg <= cfg_data[CNT_W-1:0];
                REG_FIRST_PLANE:  first_plane_reg <= cfg_data[0];
                default:          ;    // unused register slots
            endcase
        end
    end

    // size zero runs as one, anything above MAX_SIZE runs as MAX_SIZE
    always_comb
    begin
        priority if (active_size_reg == '0)
            eff_size = CNT_W'(1);
        else if (active_size_reg > CNT_W'(MAX_SIZE))
            eff_size = CNT_W'(MAX_SIZE);
        else
            eff_size = active_size_reg;
    end

    assign last_idx = eff_size + CNT_W'(1);

    // ---------------- flow control ----------------
    logic    adv;               // whole pipeline moves one stage
    logic    in_acc;            // pixel request taken this cycle
    logic    m_valid_reg;
    logic    skid_valid_reg;
    result_t m_res_reg;
    result_t skid_res_reg;
    result_t e_res;

    assign adv      = ~skid_valid_reg;
    assign s_tready = adv;
    assign in_acc   = s_tvalid & adv;

    // ---------------- raster position of the next pixel ----------------
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_we && (cfg_index == REG_ACTIVE_SIZE))
        begin
            // new size restarts the stream
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_acc)
        begin
            if (col_reg >= last_idx)
            begin
                col_reg <= '0;
                row_reg <= (row_reg >= last_idx) ? '0 : row_reg + CNT_W'(1);
            end
            else
            begin
                col_reg <= col_reg + CNT_W'(1);
            end
        end
    end

    // ---------------- stage a: pixel plus line store read ----------------
    logic                          a_valid_reg;
    logic signed [PIXEL_WIDTH-1:0] a_pix_reg;
    logic [CNT_W-1:0]              a_row_reg;
    logic [CNT_W-1:0]              a_col_reg;
    logic [2*PIXEL_WIDTH-1:0]      line_rdata;   // {row above, two rows above}
    logic signed [PIXEL_WIDTH-1:0] line_top;
    logic signed [PIXEL_WIDTH-1:0] line_mid;
    logic                          a_win;        // full window at this pixel
    logic                          a_last;
    logic [ACC_AW-1:0]             a_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_pix_reg <= s_tdata[PIXEL_WIDTH-1:0];
            a_row_reg <= row_reg;
            a_col_reg <= col_reg;
        end
    end

    c3pa_ram #(
        .WIDTH (2 * PIXEL_WIDTH),
        .DEPTH (LINE_LEN),
        .AW    (LINE_AW)
    ) u_line_ram (
        .clk   (clk),
        .we    (adv & a_valid_reg),
        .waddr (a_col_reg[LINE_AW-1:0]),
        .wdata ({a_pix_reg, line_mid}),
        .re    (in_acc),
        .raddr (col_reg[LINE_AW-1:0]),
        .rdata (line_rdata)
    );

    assign line_top = line_rdata[PIXEL_WIDTH-1:0];
    assign line_mid = line_rdata[2*PIXEL_WIDTH-1:PIXEL_WIDTH];
    assign a_win    = (a_row_reg >= CNT_W'(2)) && (a_col_reg >= CNT_W'(2));
    assign a_last   = (a_row_reg == last_idx) && (a_col_reg == last_idx);

    // accumulator entry of window top-left (row - 2, col - 2)
    assign a_addr = ACC_AW'(ACC_AW'(a_row_reg - CNT_W'(2)) * ACC_AW'(MAX_SIZE))
                  + ACC_AW'(a_col_reg - CNT_W'(2));

    // ---------------- stage b: 3x3 window ----------------
    logic signed [PIXEL_WIDTH-1:0] win_reg [9];
    logic                          b_valid_reg;
    logic [CNT_W-1:0]              b_row_reg;
    logic [CNT_W-1:0]              b_col_reg;
    logic                          b_last_reg;
    logic [ACC_AW-1:0]             b_addr_reg;
    logic [ACC_W-1:0]              acc_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg & a_win;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && a_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[3*r]     <= win_reg[3*r + 1];
                win_reg[3*r + 1] <= win_reg[3*r + 2];
            end
            win_reg[2] <= line_top;
            win_reg[5] <= line_mid;
            win_reg[8] <= a_pix_reg;
            b_row_reg  <= a_row_reg - CNT_W'(1);
            b_col_reg  <= a_col_reg - CNT_W'(1);
            b_last_reg <= a_last;
            b_addr_reg <= a_addr;
        end
    end

    // ---------------- stage c: nine products ----------------
    logic signed [WEIGHT_W-1:0] weight [9];
    logic signed [PROD_W-1:0]   prod   [9];
    logic signed [PROD_W-1:0]   c_prod_reg [9];
    logic                       c_valid_reg;
    logic [CNT_W-1:0]           c_row_reg;
    logic [CNT_W-1:0]           c_col_reg;
    logic                       c_last_reg;
    logic [ACC_AW-1:0]          c_addr_reg;
    logic [ACC_W-1:0]           c_acc_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                weight[3*r + c] = kernel_reg[r][WEIGHT_W*c +: WEIGHT_W];
            end
        end
        for (int k = 0; k < 9; k++)
        begin
            prod[k] = win_reg[k] * weight[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_valid_reg)
        begin
            for (int k = 0; k < 9; k++)
            begin
                c_prod_reg[k] <= prod[k];
            end
            c_row_reg  <= b_row_reg;
            c_col_reg  <= b_col_reg;
            c_last_reg <= b_last_reg;
            c_addr_reg <= b_addr_reg;
            c_acc_reg  <= acc_rdata;
        end
    end

    // ---------------- stage d: row partial sums ----------------
    logic signed [PART_W-1:0] d_part_reg [3];
    logic                     d_valid_reg;
    logic [CNT_W-1:0]         d_row_reg;
    logic [CNT_W-1:0]         d_col_reg;
    logic                     d_last_reg;
    logic [ACC_AW-1:0]        d_addr_reg;
    logic [ACC_W-1:0]         d_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && c_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                d_part_reg[r] <= PART_W'(c_prod_reg[3*r])
                               + PART_W'(c_prod_reg[3*r + 1])
                               + PART_W'(c_prod_reg[3*r + 2]);
            end
            d_row_reg  <= c_row_reg;
            d_col_reg  <= c_col_reg;
            d_last_reg <= c_last_reg;
            d_addr_reg <= c_addr_reg;
            d_acc_reg  <= c_acc_reg;
        end
    end

    // ---------------- stage e: window sum, accumulate, saturate ----------------
    logic signed [SUM_W-1:0]  e_sum_reg;
    logic                     e_valid_reg;
    logic [CNT_W-1:0]         e_row_reg;
    logic [CNT_W-1:0]         e_col_reg;
    logic                     e_last_reg;
    logic [ACC_AW-1:0]        e_addr_reg;
    logic [ACC_W-1:0]         e_acc_reg;
    logic signed [EXT_W-1:0]  ext_sum;
    logic signed [EXT_W-1:0]  ext_acc;
    logic signed [EXT_W-1:0]  total;
    logic [EXT_W-ACC_W:0]     total_hi;
    logic signed [ACC_W-1:0]  sat_acc;

    // previous planes' value, read while the window forms
    c3pa_ram #(
        .WIDTH (ACC_W),
        .DEPTH (ACC_DEPTH),
        .AW    (ACC_AW)
    ) u_acc_ram (
        .clk   (clk),
        .we    (adv & e_valid_reg),
        .waddr (e_addr_reg),
        .wdata (e_res.acc),
        .re    (adv & a_valid_reg & a_win),
        .raddr (a_addr),
        .rdata (acc_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && d_valid_reg)
        begin
            e_sum_reg  <= SUM_W'(d_part_reg[0]) + SUM_W'(d_part_reg[1])
                        + SUM_W'(d_part_reg[2]);
            e_row_reg  <= d_row_reg;
            e_col_reg  <= d_col_reg;
            e_last_reg <= d_last_reg;
            e_addr_reg <= d_addr_reg;
            e_acc_reg  <= d_acc_reg;
        end
    end

    always_comb
    begin
        ext_sum  = EXT_W'(e_sum_reg);
        ext_acc  = EXT_W'(signed'(e_acc_reg));
        total    = first_plane_reg ? ext_sum : ext_sum + ext_acc;
        total_hi = total[EXT_W-1:ACC_W-1];
        // in range when all bits above the accumulator sign agree with it
        if ((&total_hi) || (~|total_hi))
            sat_acc = total[ACC_W-1:0];
        else if (total[EXT_W-1])
            sat_acc = {1'b1, {(ACC_W-1){1'b0}}};
        else
            sat_acc = {1'b0, {(ACC_W-1){1'b1}}};
    end

    assign e_res.row  = e_row_reg;
    assign e_res.col  = e_col_reg;
    assign e_res.acc  = sat_acc;
    assign e_res.last = e_last_reg;

    // ---------------- output register and skid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_valid_reg && !m_tready)
        begin
            // sink stalled: a new result parks in the skid
            if (adv && e_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            m_valid_reg    <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= adv & e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_valid_reg && !m_tready)
        begin
            if (adv && e_valid_reg)
            begin
                skid_res_reg <= e_res;
            end
        end
        else if (skid_valid_reg)
        begin
            m_res_reg <= skid_res_reg;
        end
        else if (adv && e_valid_reg)
        begin
            m_res_reg <= e_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                       m_res_reg.acc, m_res_reg.col, m_res_reg.row};

endmodule

[hdl/c3pa_ram.sv]
// generic simple dual-port ram, one write port, one registered read port
module c3pa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/c3pa_checker.sv]
// port-level checks of the convolution core, bound to the top level
`include "conv3x3_plane_accumulate_core_macros.svh"

module c3pa_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [c3pa_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);

    import c3pa_pkg::*;

    // a stalled result holds still
    `C3PA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // requests are refused only after the sink held off a result
    `C3PA_ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !s_tready, $past(m_tvalid && !m_tready))

    // the last window of a plane sits on the diagonal corner
    `C3PA_ASSERT_IMPLIES(a_last_corner, clk, rst_n, m_tvalid && m_tlast, m_tdata[OUT_ROW_LSB +: CNT_W] == m_tdata[OUT_COL_LSB +: CNT_W])

    // window centers never sit on the padding row or column zero
    `C3PA_ASSERT_IMPLIES(a_center_inside, clk, rst_n, m_tvalid, (m_tdata[OUT_ROW_LSB +: CNT_W] != '0) && (m_tdata[OUT_COL_LSB +: CNT_W] != '0))

endmodule

bind conv3x3_plane_accumulate_core c3pa_checker u_c3pa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
